// File: rtl/pfla_pkg.sv
package pfla_pkg;

   // sizing
   localparam int TABLES          = 16;
   localparam int PAGES_PER_TABLE = 4096;
   localparam int RESERVE_BATCH   = 8;

   // field widths fixed by the interface
   localparam int CMD_W      = 2;
   localparam int TABLE_ID_W = 4;
   localparam int PAGE_NUM_W = 12;
   localparam int STATUS_W   = 2;

   // derived widths
   localparam int TBL_W  = $clog2(TABLES);
   localparam int PAGE_W = $clog2(PAGES_PER_TABLE);
   localparam int CNT_W  = $clog2(PAGES_PER_TABLE + 1);
   localparam int IDX_W  = (RESERVE_BATCH > 1) ? $clog2(RESERVE_BATCH) : 1;
   localparam int LINKS  = TABLES * PAGES_PER_TABLE;
   localparam int ADDR_W = $clog2(LINKS);

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

   // datapath commit operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
   localparam logic [OP_W-1:0] OP_POP      = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE     = 3'd2;
   localparam logic [OP_W-1:0] OP_INIT     = 3'd3;
   localparam logic [OP_W-1:0] OP_EXT_STEP = 3'd4;
   localparam logic [OP_W-1:0] OP_EXT_LAST = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic                capture;
      logic                rd_link;
      logic [OP_W-1:0]     op;
      logic                set_result;
      logic [STATUS_W-1:0] res_status;
      logic                load_rsp;
   } pfla_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             table_bad;
      logic             head_zero;
      logic             ext_full;
      logic             free_bad;
      logic             ext_last;
   } pfla_stat_type;

endpackage

// File: rtl/pfla_dp.sv
module pfla_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  pfla_pkg::pfla_cmd_type             cmd,
   output pfla_pkg::pfla_stat_type            stat,
   input  logic [pfla_pkg::CMD_W-1:0]         req_command,
   input  logic [pfla_pkg::TABLE_ID_W-1:0]    req_table_id,
   input  logic [pfla_pkg::PAGE_NUM_W-1:0]    req_page_number,
   output logic [pfla_pkg::PAGE_NUM_W-1:0]    rsp_allocated_page,
   output logic [pfla_pkg::STATUS_W-1:0]      rsp_status
);

   // captured request
   logic [pfla_pkg::CMD_W-1:0]      command_ff;
   logic [pfla_pkg::TABLE_ID_W-1:0] table_ff;
   logic [pfla_pkg::PAGE_NUM_W-1:0] page_ff;
   logic [pfla_pkg::IDX_W-1:0]      ext_idx_ff;
   logic [pfla_pkg::IDX_W-1:0]      ext_idx_in;

   // per-table allocator state
   logic [pfla_pkg::PAGE_W-1:0] head_ff  [pfla_pkg::TABLES];
   logic [pfla_pkg::CNT_W-1:0]  count_ff [pfla_pkg::TABLES];
   logic                        head_we;
   logic [pfla_pkg::PAGE_W-1:0] head_in;
   logic                        count_we;
   logic [pfla_pkg::CNT_W-1:0]  count_in;

   // next-free link memory
   logic [pfla_pkg::PAGE_W-1:0] link_mem [pfla_pkg::LINKS];
   logic [pfla_pkg::PAGE_W-1:0] link_rd_ff;
   logic                        mem_we;
   logic [pfla_pkg::ADDR_W-1:0] mem_waddr;
   logic [pfla_pkg::PAGE_W-1:0] mem_wdata;
   logic [pfla_pkg::ADDR_W-1:0] mem_raddr;

   // pending and delivered result
   logic [pfla_pkg::PAGE_W-1:0]     pend_page_ff;
   logic [pfla_pkg::PAGE_W-1:0]     pend_page_in;
   logic [pfla_pkg::STATUS_W-1:0]   pend_status_ff;
   logic [pfla_pkg::PAGE_NUM_W-1:0] rsp_page_ff;
   logic [pfla_pkg::STATUS_W-1:0]   rsp_status_ff;

   logic [pfla_pkg::TBL_W-1:0]  tbl_idx;
   logic [pfla_pkg::PAGE_W-1:0] head_cur;
   logic [pfla_pkg::CNT_W-1:0]  cnt_cur;
   logic [pfla_pkg::CNT_W-1:0]  ext_page;
   logic [pfla_pkg::PAGE_W-1:0] freed_page;
   logic [pfla_pkg::ADDR_W-1:0] tbl_base;

   // selected table
   assign tbl_idx    = pfla_pkg::TBL_W'(table_ff);
   assign head_cur   = head_ff[tbl_idx];
   assign cnt_cur    = count_ff[tbl_idx];
   assign ext_page   = pfla_pkg::CNT_W'(cnt_cur + pfla_pkg::CNT_W'(ext_idx_ff));
   assign freed_page = pfla_pkg::PAGE_W'(page_ff);
   assign tbl_base   = pfla_pkg::ADDR_W'(pfla_pkg::ADDR_W'(tbl_idx) *
                                         pfla_pkg::ADDR_W'(pfla_pkg::PAGES_PER_TABLE));

   // status toward the controller
   assign stat.command   = command_ff;
   assign stat.table_bad = 32'(table_ff) >= pfla_pkg::TABLES;
   assign stat.head_zero = head_cur == '0;
   assign stat.ext_full  = (32'(cnt_cur) + pfla_pkg::RESERVE_BATCH) >
                           pfla_pkg::PAGES_PER_TABLE;
   assign stat.free_bad  = (page_ff == '0) || (32'(page_ff) >= 32'(cnt_cur));
   assign stat.ext_last  = ext_idx_ff == pfla_pkg::IDX_W'(pfla_pkg::RESERVE_BATCH - 1);

   // request capture and extension index
   always_comb begin
      ext_idx_in = ext_idx_ff;
      if (cmd.capture) begin
         ext_idx_in = '0;
      end else if (cmd.op == pfla_pkg::OP_EXT_STEP) begin
         ext_idx_in = pfla_pkg::IDX_W'(ext_idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff <= req_command;
         table_ff   <= req_table_id;
         page_ff    <= req_page_number;
      end
      ext_idx_ff <= ext_idx_in;
   end

   // link memory write and read port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pfla_pkg::ADDR_W'(tbl_base + pfla_pkg::ADDR_W'(ext_page));
      mem_wdata = '0;
      case (cmd.op)
         pfla_pkg::OP_FREE: begin
            mem_we    = 1'b1;
            mem_waddr = pfla_pkg::ADDR_W'(tbl_base + pfla_pkg::ADDR_W'(freed_page));
            mem_wdata = head_cur;
         end
         pfla_pkg::OP_EXT_STEP: begin
            mem_we    = 1'b1;
            mem_wdata = pfla_pkg::PAGE_W'(ext_page + 1'b1);
         end
         pfla_pkg::OP_EXT_LAST: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   assign mem_raddr = pfla_pkg::ADDR_W'(tbl_base + pfla_pkg::ADDR_W'(head_cur));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_link) begin
         link_rd_ff <= link_mem[mem_raddr];
      end
   end

   // head and count updates
   always_comb begin
      head_we  = 1'b0;
      head_in  = head_cur;
      count_we = 1'b0;
      count_in = cnt_cur;
      case (cmd.op)
         pfla_pkg::OP_POP: begin
            head_we = 1'b1;
            head_in = link_rd_ff;
         end
         pfla_pkg::OP_FREE: begin
            head_we = 1'b1;
            head_in = freed_page;
         end
         pfla_pkg::OP_INIT: begin
            head_we  = 1'b1;
            head_in  = '0;
            count_we = 1'b1;
            count_in = pfla_pkg::CNT_W'(1);
         end
         pfla_pkg::OP_EXT_LAST: begin
            // batch start is handed out, its successor becomes the head
            head_we  = 1'b1;
            head_in  = (pfla_pkg::RESERVE_BATCH > 1) ?
                       pfla_pkg::PAGE_W'(cnt_cur + 1'b1) : '0;
            count_we = 1'b1;
            count_in = pfla_pkg::CNT_W'(32'(cnt_cur) + pfla_pkg::RESERVE_BATCH);
         end
         default: begin
            head_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < pfla_pkg::TABLES; t++) begin
            head_ff[t]  <= '0;
            count_ff[t] <= pfla_pkg::CNT_W'(1);
         end
      end else begin
         if (head_we) begin
            head_ff[tbl_idx] <= head_in;
         end
         if (count_we) begin
            count_ff[tbl_idx] <= count_in;
         end
      end
   end

   // result staging
   always_comb begin
      case (cmd.op)
         pfla_pkg::OP_POP:      pend_page_in = head_cur;
         pfla_pkg::OP_EXT_LAST: pend_page_in = pfla_pkg::PAGE_W'(cnt_cur);
         default:               pend_page_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         pend_page_ff   <= pend_page_in;
         pend_status_ff <= cmd.res_status;
      end
      if (cmd.load_rsp) begin
         rsp_page_ff   <= pfla_pkg::PAGE_NUM_W'(pend_page_ff);
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign rsp_allocated_page = rsp_page_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef SYNTHESIS
   a_ext_idx_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pfla_pkg::OP_EXT_STEP) |-> !stat.ext_last)
      else $error("extension step issued on the last batch entry");

   a_free_head: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pfla_pkg::OP_FREE) |=> head_ff[$past(tbl_idx)] == $past(freed_page))
      else $error("freed page did not become the list head");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == pfla_pkg::OP_EXT_LAST) |-> !stat.ext_full)
      else $error("extension past table capacity");
`endif

endmodule

// File: rtl/pfla_ctrl.sv
module pfla_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  pfla_pkg::pfla_stat_type stat,
   output pfla_pkg::pfla_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_EXTEND = 3'd2;
   localparam logic [2:0] S_POP    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       accept;

   // output slot is free when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // sequencing
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.op         = pfla_pkg::OP_NONE;
      cmd.res_status = pfla_pkg::ST_OK;
      cmd.capture    = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_result = 1'b1;
            state_in       = S_DONE;
            if (stat.table_bad) begin
               cmd.res_status = pfla_pkg::ST_BAD;
            end else begin
               case (stat.command)
                  pfla_pkg::CMD_ALLOC: begin
                     if (!stat.head_zero) begin
                        cmd.rd_link    = 1'b1;
                        cmd.set_result = 1'b0;
                        state_in       = S_POP;
                     end else if (stat.ext_full) begin
                        cmd.res_status = pfla_pkg::ST_FULL;
                     end else begin
                        cmd.set_result = 1'b0;
                        state_in       = S_EXTEND;
                     end
                  end
                  pfla_pkg::CMD_FREE: begin
                     if (stat.free_bad) begin
                        cmd.res_status = pfla_pkg::ST_BAD;
                     end else begin
                        cmd.op = pfla_pkg::OP_FREE;
                     end
                  end
                  pfla_pkg::CMD_INIT: begin
                     cmd.op = pfla_pkg::OP_INIT;
                  end
                  default: begin
                     cmd.op = pfla_pkg::OP_NONE;
                  end
               endcase
            end
         end
         S_EXTEND: begin
            // chain one new page per cycle
            if (stat.ext_last) begin
               cmd.op         = pfla_pkg::OP_EXT_LAST;
               cmd.set_result = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.op = pfla_pkg::OP_EXT_STEP;
            end
         end
         S_POP: begin
            cmd.op         = pfla_pkg::OP_POP;
            cmd.set_result = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = accept ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((state_ff == S_IDLE) || (state_ff == S_DONE)))
      else $error("request taken while an item is in progress");

   a_ext_exit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_EXTEND) && stat.ext_last) |=> (state_ff == S_DONE))
      else $error("extension did not finish after its last step");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("result overwritten before it was taken");
`endif

endmodule

// File: rtl/page_free_list_allocator.sv
// accept to result valid: free, init, rejected or store-full commands go from
// S_EXEC to S_DONE; an allocate from a non-empty list passes S_POP for the link
// memory read; an allocate that extends the table passes S_EXTEND for the batch.
// throughput: the next beat is taken at the edge that loads the result and
// not before; extension writes one link a cycle.
// reset: heads cleared to 0 and counts set to 1; links not cleared.
module page_free_list_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pfla_pkg::CMD_W-1:0]         req_command,
   input  logic [pfla_pkg::TABLE_ID_W-1:0]    req_table_id,
   input  logic [pfla_pkg::PAGE_NUM_W-1:0]    req_page_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pfla_pkg::PAGE_NUM_W-1:0]    rsp_allocated_page,
   output logic [pfla_pkg::STATUS_W-1:0]      rsp_status
);

   pfla_pkg::pfla_cmd_type  cmd;
   pfla_pkg::pfla_stat_type stat;

   // sequencer
   pfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // allocator state, link memory and result registers
   pfla_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_command        (req_command),
      .req_table_id       (req_table_id),
      .req_page_number    (req_page_number),
      .rsp_allocated_page (rsp_allocated_page),
      .rsp_status         (rsp_status)
   );

endmodule
